// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define AST_PROP(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Same-cycle implication, switched off while reset is asserted.
`define AST_IMPLY(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/saq_pkg.sv =====
// Types and constants of the sorted alarm queue.
package saq_pkg;

  localparam int unsigned SLOTS_DEF = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned HOURS_W   = 21;
  localparam int unsigned MS_W      = 6;
  localparam int unsigned CNT_OUT_W = 5;
  localparam int unsigned REM_W     = 12;

  // hours = ((t >> 4) * HOUR_RECIP) >> 36, exact for all 32-bit t
  localparam logic [28:0] HOUR_RECIP = 29'd305419897;
  localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
  // minutes = ((rem >> 2) * MIN_RECIP) >> 14, exact for rem < 3600
  localparam logic [10:0] MIN_RECIP = 11'd1093;
  localparam logic [5:0]  SEC_PER_MIN = 6'd60;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_ZERO_REJ = 3'd1,
    ST_FULL_REJ = 3'd2,
    ST_FIRED    = 3'd3,
    ST_NOT_DUE  = 3'd4
  } status_e;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_TICK   = 1'b1
  } req_e;

  // broadcast to every cell
  typedef struct packed {
    logic              ins;
    logic              pop;
    logic [TIME_W-1:0] t;
  } cell_cmd_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic              take;
    logic [TIME_W-1:0] value;
  } cell_link_t;

  // result fields riding along the h:m:s pipeline
  typedef struct packed {
    status_e              status;
    logic                 fired;
    logic [CNT_OUT_W-1:0] count;
    logic                 evalid;
  } res_info_t;

endpackage

// ===== hdl/sorted_alarm_queue.sv =====
// Top level of the sorted alarm queue: cell chain, count and result pipeline.
//
// Usage:
//   A request is transferred when start_i is high and busy_o is low; busy_o
//   is always low, so a request can be given in every cycle.
//   req_type_i = insert: time_value_i is stored in ascending order, ahead of
//   any equal time already held. Zero is rejected, as is an insert when all
//   ALARM_SLOTS slots are held.
//   req_type_i = tick: time_value_i is the current time; the earliest alarm
//   is removed and fired_o raised when it is due (now >= alarm).
//   Each request yields one result, shown for exactly one cycle with done_o
//   high, after the transfer has passed the cell chain register and the
//   three h:m:s pipeline stages (hour multiply, remainder, minute multiply).
//   Results come out in request order, one per cycle at most. The receiver
//   cannot hold them off and has no stall input.
//   Every slot is one cell comparing against the broadcast time and shifting
//   to its neighbor, so insert and remove both act on all slots at once,
//   whatever the fill level.
//   Reset clears the count and the valid flags of the result pipeline; slot contents are not
//   cleared and are only read below the count.
module sorted_alarm_queue
  import saq_pkg::*;
#(
  parameter int unsigned ALARM_SLOTS = SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               req_type_i,
  input  logic [TIME_W-1:0]  time_value_i,
  output logic               done_o,
  output logic [2:0]         status_o,
  output logic               fired_o,
  output logic [4:0]         held_count_o,
  output logic               earliest_valid_o,
  output logic [HOURS_W-1:0] earliest_hours_o,
  output logic [MS_W-1:0]    earliest_minutes_o,
  output logic [MS_W-1:0]    earliest_seconds_o
);

  localparam int unsigned CNT_W = $clog2(ALARM_SLOTS + 1);

  logic [CNT_W-1:0] count_q, count_d;
  logic             accept, is_tick, full, zero_t, due;
  status_e          status_d;
  cell_cmd_t        cmd;
  cell_link_t       link [ALARM_SLOTS];

  logic             s1_vld_q;
  status_e          s1_status_q;
  logic             s1_fired_q;
  res_info_t        hms_info_in, hms_info_out;
  logic [TIME_W-1:0] head_secs;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign is_tick = (req_type_i == REQ_TICK);
  assign full    = (count_q == CNT_W'(ALARM_SLOTS));
  assign zero_t  = (time_value_i == '0);
  // head cell holds the earliest alarm
  assign due     = (count_q != '0) && (time_value_i >= link[0].value);

  assign cmd.ins = accept && !is_tick && !zero_t && !full;
  assign cmd.pop = accept && is_tick && due;
  assign cmd.t   = time_value_i;

  always_comb begin
    count_d = count_q;
    priority if (cmd.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd.pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    priority if (is_tick) begin
      status_d = due ? ST_FIRED : ST_NOT_DUE;
    end else if (zero_t) begin
      status_d = ST_ZERO_REJ;
    end else if (full) begin
      status_d = ST_FULL_REJ;
    end else begin
      status_d = ST_INSERTED;
    end
  end

  // the chain: cell 0 is the earliest alarm
  for (genvar i = 0; i < ALARM_SLOTS; i++) begin : g_cell
    cell_link_t        left;
    logic [TIME_W-1:0] right_value;
    logic              slot_valid;

    assign slot_valid = (count_q > CNT_W'(i));

    if (i == 0) begin : g_first
      assign left.take  = 1'b0;
      assign left.value = '0;
    end else begin : g_mid
      assign left = link[i-1];
    end

    if (i == ALARM_SLOTS - 1) begin : g_last
      assign right_value = '0;
    end else begin : g_inner
      assign right_value = link[i+1].value;
    end

    saq_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .valid_i       (slot_valid),
      .left_i        (left),
      .right_value_i (right_value),
      .link_o        (link[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      s1_vld_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_status_q <= status_d;
    s1_fired_q  <= cmd.pop;
  end

  // after the chain update count_q and cell 0 already show the new state
  assign head_secs          = (count_q != '0) ? link[0].value : '0;
  assign hms_info_in.status = s1_status_q;
  assign hms_info_in.fired  = s1_fired_q;
  assign hms_info_in.count  = CNT_OUT_W'(count_q);
  assign hms_info_in.evalid = (count_q != '0);

  saq_hms u_hms (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vld_i     (s1_vld_q),
    .secs_i    (head_secs),
    .info_i    (hms_info_in),
    .vld_o     (done_o),
    .info_o    (hms_info_out),
    .hours_o   (earliest_hours_o),
    .minutes_o (earliest_minutes_o),
    .seconds_o (earliest_seconds_o)
  );

  assign status_o         = hms_info_out.status;
  assign fired_o          = hms_info_out.fired;
  assign held_count_o     = hms_info_out.count;
  assign earliest_valid_o = hms_info_out.evalid;

endmodule

// ===== hdl/saq_cell.sv =====
// One slot of the sorted chain: compare against the new time, shift in or out.
module saq_cell
  import saq_pkg::*;
(
  input  logic              clk_i,
  input  cell_cmd_t         cmd_i,
  input  logic              valid_i,
  input  cell_link_t        left_i,
  input  logic [TIME_W-1:0] right_value_i,
  output cell_link_t        link_o
);

  logic [TIME_W-1:0] value_q, value_d;
  logic              take;

  // empty slots count as +infinity
  assign take = !valid_i || (value_q >= cmd_i.t);

  always_comb begin
    value_d = value_q;
    priority if (cmd_i.ins && take) begin
      value_d = left_i.take ? left_i.value : cmd_i.t;
    end else if (cmd_i.pop) begin
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign link_o.take  = take;
  assign link_o.value = value_q;

endmodule

// ===== hdl/saq_hms.sv =====
// Pipelined split of a seconds count into hours, minutes and seconds.
module saq_hms
  import saq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  logic [TIME_W-1:0]  secs_i,
  input  res_info_t          info_i,
  output logic               vld_o,
  output res_info_t          info_o,
  output logic [HOURS_W-1:0] hours_o,
  output logic [MS_W-1:0]    minutes_o,
  output logic [MS_W-1:0]    seconds_o
);

  logic [56:0]        hprod;
  logic [HOURS_W-1:0] a_hours_q;
  logic [REM_W-1:0]   a_lo_q;
  logic               a_vld_q;
  res_info_t          a_info_q;

  logic [HOURS_W-1:0] b_hours_q;
  logic [REM_W-1:0]   b_rem_q, b_rem_d;
  logic               b_vld_q;
  res_info_t          b_info_q;

  logic [20:0]        mprod;
  logic [MS_W-1:0]    c_min_d, c_sec_d;
  logic [REM_W-1:0]   min_sec;
  logic [MS_W-1:0]    c_min_q, c_sec_q;
  logic [HOURS_W-1:0] c_hours_q;
  logic               c_vld_q;
  res_info_t          c_info_q;

  // stage A: hours by reciprocal multiply
  assign hprod = 57'(secs_i[TIME_W-1:4]) * 57'(HOUR_RECIP);

  // stage B: remainder within the hour, low 12 bits suffice
  assign b_rem_d = a_lo_q - REM_W'(a_hours_q * SEC_PER_HOUR);

  // stage C: minutes by reciprocal multiply, seconds as what is left
  assign mprod   = 21'(b_rem_q[REM_W-1:2]) * 21'(MIN_RECIP);
  assign c_min_d = mprod[19:14];
  assign min_sec = REM_W'(c_min_d) * REM_W'(SEC_PER_MIN);
  assign c_sec_d = MS_W'(b_rem_q - min_sec);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      a_vld_q <= vld_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_hours_q <= hprod[56:36];
    a_lo_q    <= secs_i[REM_W-1:0];
    a_info_q  <= info_i;
    b_hours_q <= a_hours_q;
    b_rem_q   <= b_rem_d;
    b_info_q  <= a_info_q;
    c_hours_q <= b_hours_q;
    c_min_q   <= c_min_d;
    c_sec_q   <= c_sec_d;
    c_info_q  <= b_info_q;
  end

  assign vld_o     = c_vld_q;
  assign info_o    = c_info_q;
  assign hours_o   = c_hours_q;
  assign minutes_o = c_min_q;
  assign seconds_o = c_sec_q;

endmodule

// ===== hdl/saq_checker.sv =====
// Port-level checks of the sorted alarm queue, bound to the top level.
`include "assert_macros.svh"

module saq_checker
  import saq_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               req_type_i,
  input logic [TIME_W-1:0]  time_value_i,
  input logic               done_o,
  input logic [2:0]         status_o,
  input logic               fired_o,
  input logic [4:0]         held_count_o,
  input logic               earliest_valid_o,
  input logic [HOURS_W-1:0] earliest_hours_o,
  input logic [MS_W-1:0]    earliest_minutes_o,
  input logic [MS_W-1:0]    earliest_seconds_o
);

  `AST_IMPLY(a_done_has_req, clk_i, rst_ni, done_o, $past(start_i && !busy_o, 4), "result without request")
  `AST_IMPLY(a_fired_status, clk_i, rst_ni, done_o && fired_o, status_o == ST_FIRED, "fired without fired status")
  `AST_IMPLY(a_empty_zero, clk_i, rst_ni, done_o && !earliest_valid_o, (earliest_hours_o == '0) && (earliest_minutes_o == '0) && (earliest_seconds_o == '0) && (held_count_o == '0), "empty queue shows a time")
  `AST_IMPLY(a_ms_range, clk_i, rst_ni, done_o, (earliest_minutes_o < 6'd60) && (earliest_seconds_o < 6'd60), "minutes or seconds out of range")
  `AST_IMPLY(a_insert_nonempty, clk_i, rst_ni, done_o && (status_o == ST_INSERTED), earliest_valid_o && (held_count_o != '0), "insert left queue empty")

endmodule

bind sorted_alarm_queue saq_checker u_saq_checker (.*);

// ===== tb/sv/sorted_alarm_queue_tb.sv =====
// Self-checking testbench for the sorted alarm queue: directed table, then random traffic.
module sorted_alarm_queue_tb;
  import saq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = SLOTS_DEF;
  localparam int RANDOM_REQS = 1850;
  localparam int SHOW_MAX = 40;    // mismatch lines printed before going quiet
  localparam int DRAIN_LIMIT = 200;
  localparam int TAIL_CYCLES = 8;  // result pipeline is four deep, allow a margin

  // One result, one field per output port.
  typedef struct packed {
    status_e              status;
    logic                 fired;
    logic [4:0]           count;
    logic                 evalid;
    logic [HOURS_W-1:0]   hours;
    logic [MS_W-1:0]      minutes;
    logic [MS_W-1:0]      seconds;
  } alarm_report_t;

  // One directed row. When pinned is set, the report is typed in by hand.
  typedef struct {
    req_e              req;
    logic [TIME_W-1:0] t;
    bit                pinned;
    alarm_report_t     report;
  } script_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               req_type_i = 1'b0;
  logic [TIME_W-1:0]  time_value_i = '0;
  logic               busy_o;
  logic               done_o;
  logic [2:0]         status_o;
  logic               fired_o;
  logic [4:0]         held_count_o;
  logic               earliest_valid_o;
  logic [HOURS_W-1:0] earliest_hours_o;
  logic [MS_W-1:0]    earliest_minutes_o;
  logic [MS_W-1:0]    earliest_seconds_o;

  // Shadow copy of the alarm list, kept sorted exactly like the block.
  logic [TIME_W-1:0]  shadow_times [SLOTS];
  int                 shadow_count = 0;

  // Reports still owed by the block, oldest first.
  alarm_report_t      owed_reports [$];
  script_row_t        script [$];

  int mismatches = 0;
  int reports_seen = 0;
  int n_inserts = 0, n_ticks = 0, n_fired = 0, n_zero_rej = 0, n_full_rej = 0;
  int peak_count = 0;

  sorted_alarm_queue #(
    .ALARM_SLOTS(SLOTS)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .req_type_i        (req_type_i),
    .time_value_i      (time_value_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .fired_o           (fired_o),
    .held_count_o      (held_count_o),
    .earliest_valid_o  (earliest_valid_o),
    .earliest_hours_o  (earliest_hours_o),
    .earliest_minutes_o(earliest_minutes_o),
    .earliest_seconds_o(earliest_seconds_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Hard stop in case the block never answers.
  initial begin
    #20_000_000;
    $display("timeout: %0d reports still owed", owed_reports.size());
    $display("** sorted_alarm_queue: FAILED **");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= SHOW_MAX) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Applies one request to the shadow list and returns the report it yields.
  // Insert goes ahead of the first stored time >= t, so a new time lands
  // ahead of equal ones. A tick pops at most one alarm, and only when it is due.
  function automatic alarm_report_t alarm_queue_step(input req_e req,
                                                     input logic [TIME_W-1:0] t);
    alarm_report_t     r;
    logic [TIME_W-1:0] head;
    int                i;
    r = '0;
    r.status = ST_NOT_DUE;
    if (req == REQ_INSERT) begin
      if (t == '0) begin
        r.status = ST_ZERO_REJ;
      end else if (shadow_count >= SLOTS) begin
        r.status = ST_FULL_REJ;
      end else begin
        // stored times >= t form a tail of the sorted list; slide it up
        i = shadow_count;
        while (i > 0 && shadow_times[i-1] >= t) begin
          shadow_times[i] = shadow_times[i-1];
          i--;
        end
        shadow_times[i] = t;
        shadow_count++;
        r.status = ST_INSERTED;
      end
    end else if (shadow_count > 0 && t >= shadow_times[0]) begin
      for (i = 1; i < shadow_count; i++) shadow_times[i-1] = shadow_times[i];
      shadow_count--;
      r.status = ST_FIRED;
      r.fired = 1'b1;
    end
    head = (shadow_count > 0) ? shadow_times[0] : '0;
    r.count = shadow_count[4:0];
    r.evalid = (shadow_count > 0);
    r.hours = HOURS_W'(head / 32'd3600);
    r.minutes = MS_W'((head % 32'd3600) / 32'd60);
    r.seconds = MS_W'(head % 32'd60);
    return r;
  endfunction

  function automatic alarm_report_t hms_report(input status_e st, input logic fired,
                                               input int cnt, input int h,
                                               input int m, input int s);
    alarm_report_t r;
    r.status = st;
    r.fired = fired;
    r.count = cnt[4:0];
    r.evalid = (cnt > 0);
    r.hours = h[HOURS_W-1:0];
    r.minutes = m[MS_W-1:0];
    r.seconds = s[MS_W-1:0];
    return r;
  endfunction

  task automatic add_row(input req_e req, input logic [TIME_W-1:0] t,
                         input bit pinned, input alarm_report_t report);
    script_row_t row;
    row.req = req;
    row.t = t;
    row.pinned = pinned;
    row.report = report;
    script.push_back(row);
  endtask

  // Holds the request until busy_o is low at a rising edge, then books the
  // report it owes. start_i stays high; the caller lowers it for a gap or at the end.
  task automatic send_request(input req_e req, input logic [TIME_W-1:0] t,
                              input bit pinned, input alarm_report_t pinned_report);
    alarm_report_t r;
    start_i <= 1'b1;
    req_type_i <= req;
    time_value_i <= t;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    r = alarm_queue_step(req, t);
    owed_reports.push_back(pinned ? pinned_report : r);
    if (req == REQ_INSERT) n_inserts++;
    else n_ticks++;
    case (r.status)
      ST_FIRED:    n_fired++;
      ST_ZERO_REJ: n_zero_rej++;
      ST_FULL_REJ: n_full_rej++;
      default: ;
    endcase
    if (shadow_count > peak_count) peak_count = shadow_count;
  endtask

  // Sender gap: mostly none, some short, a few long; none at all when quiet.
  task automatic sender_gap(input bit quiet);
    int roll;
    int n;
    roll = $urandom_range(0, 99);
    n = 0;
    if (!quiet) begin
      if (roll >= 92) n = $urandom_range(8, 30);
      else if (roll >= 60) n = $urandom_range(1, 3);
    end
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Result monitor: every done_o pulse is one transfer, matched against the
  // oldest owed report. Outputs are sampled at the edge that ends the cycle.
  always @(posedge clk_i) begin
    alarm_report_t want;
    if (rst_ni && done_o) begin
      reports_seen++;
      if (owed_reports.size() == 0) begin
        report_mismatch($sformatf("report #%0d with nothing owed (status %0d)",
                                  reports_seen, status_o));
      end else begin
        want = owed_reports.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("#%0d status %0d, want %0d",
                                    reports_seen, status_o, want.status));
        if (fired_o !== want.fired)
          report_mismatch($sformatf("#%0d fired %0b, want %0b",
                                    reports_seen, fired_o, want.fired));
        if (held_count_o !== want.count)
          report_mismatch($sformatf("#%0d held_count %0d, want %0d",
                                    reports_seen, held_count_o, want.count));
        if (earliest_valid_o !== want.evalid)
          report_mismatch($sformatf("#%0d earliest_valid %0b, want %0b",
                                    reports_seen, earliest_valid_o, want.evalid));
        if (earliest_hours_o !== want.hours)
          report_mismatch($sformatf("#%0d hours %0d, want %0d",
                                    reports_seen, earliest_hours_o, want.hours));
        if (earliest_minutes_o !== want.minutes)
          report_mismatch($sformatf("#%0d minutes %0d, want %0d",
                                    reports_seen, earliest_minutes_o, want.minutes));
        if (earliest_seconds_o !== want.seconds)
          report_mismatch($sformatf("#%0d seconds %0d, want %0d",
                                    reports_seen, earliest_seconds_o, want.seconds));
      end
    end
  end

  initial begin
    logic [TIME_W-1:0] fill_times [13];
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] t;
    alarm_report_t     none;
    req_e              req;
    int                insert_pct;
    bit                quiet;
    int                roll;
    int                guard;

    none = '0;
    fill_times = '{32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
                   32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFE};

    // Directed table. Hand-typed reports where the answer is plain.
    // tick on an empty queue, time zero
    add_row(REQ_TICK, 32'd0, 1'b1, hms_report(ST_NOT_DUE, 1'b0, 0, 0, 0, 0));
    // zero time is refused
    add_row(REQ_INSERT, 32'd0, 1'b1, hms_report(ST_ZERO_REJ, 1'b0, 0, 0, 0, 0));
    // largest time: 1193046 h 28 m 15 s
    add_row(REQ_INSERT, 32'hFFFF_FFFF, 1'b1,
            hms_report(ST_INSERTED, 1'b0, 1, 1193046, 28, 15));
    // one second early, not due
    add_row(REQ_TICK, 32'hFFFF_FFFE, 1'b1,
            hms_report(ST_NOT_DUE, 1'b0, 1, 1193046, 28, 15));
    // exactly due
    add_row(REQ_TICK, 32'hFFFF_FFFF, 1'b1, hms_report(ST_FIRED, 1'b1, 0, 0, 0, 0));
    add_row(REQ_INSERT, 32'd1, 1'b1, hms_report(ST_INSERTED, 1'b0, 1, 0, 0, 1));
    add_row(REQ_INSERT, 32'd3661, 1'b0, none);
    // equal time goes ahead of the one already stored
    add_row(REQ_INSERT, 32'd1, 1'b0, none);
    // tick at time zero is compared like any other
    add_row(REQ_TICK, 32'd0, 1'b0, none);
    foreach (fill_times[i]) add_row(REQ_INSERT, fill_times[i], 1'b0, none);
    // all slots held now
    add_row(REQ_INSERT, 32'd7, 1'b1, hms_report(ST_FULL_REJ, 1'b0, SLOTS, 0, 0, 1));
    add_row(REQ_TICK, 32'hFFFF_FFFF, 1'b0, none);
    // the freed slot takes a new alarm
    add_row(REQ_INSERT, 32'd5, 1'b0, none);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      send_request(script[i].req, script[i].t, script[i].pinned, script[i].report);
      sender_gap(1'b0);
    end

    // Random traffic. Alarms are mostly set a little ahead of a moving
    // current time and ticks advance it, so the list fills, drains and
    // fires often. The insert share shifts every block of requests.
    now = 32'd1000;
    insert_pct = 50;
    quiet = 1'b0;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 150 == 0) begin
        insert_pct = $urandom_range(15, 85);
        quiet = ($urandom_range(0, 3) == 0);
      end
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < insert_pct) begin
        req = REQ_INSERT;
        if (roll < 5) t = '0;
        else if (roll < 15) t = $urandom;
        else if (roll < 25 && shadow_count > 0)
          t = shadow_times[$urandom_range(0, shadow_count - 1)];
        else t = now + $urandom_range(0, 600);
      end else begin
        req = REQ_TICK;
        if (roll < 8) t = $urandom;
        else if (roll < 14) t = '0;
        else if (roll < 18) t = 32'hFFFF_FFFF;
        else begin
          now = now + $urandom_range(0, 120);
          t = now;
        end
      end
      send_request(req, t, 1'b0, none);
      sender_gap(quiet);
    end
    start_i <= 1'b0;

    guard = 0;
    while (owed_reports.size() > 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    while (owed_reports.size() > 0) begin
      void'(owed_reports.pop_front());
      report_mismatch("report never delivered");
    end

    $display("covered %0d inserts, %0d ticks, %0d alarms fired",
             n_inserts, n_ticks, n_fired);
    $display("rejects: %0d zero time, %0d full; deepest fill %0d of %0d; %0d mismatches",
             n_zero_rej, n_full_rej, peak_count, SLOTS, mismatches);
    if (mismatches == 0) begin
      $display("** sorted_alarm_queue: PASSED **");
    end else begin
      $display("** sorted_alarm_queue: FAILED **");
    end
    $finish;
  end

endmodule
